/* src/sgm_pkg.sv */
package sgm_pkg;

    // default size of the pattern store, in characters
    localparam int MAX_PATTERN_DEF = 32;

    // the only wildcard byte
    localparam logic [7:0] STAR_CHAR = 8'd42;

    // operation codes carried on the input channel
    typedef enum logic {
        OP_LOAD = 1'b0,
        OP_NAME = 1'b1
    } t_op;

    // what one cell hands to the next position in the row
    typedef struct packed {
        logic shift;    // literal matched here, position i+1 becomes active
        logic carry;    // active star here, position i+1 is active as well
    } t_link;

endpackage

/* src/star_glob_matcher.sv */
// a result transaction appears in the cycle after the last name character is taken
// throughput: one input transaction per cycle, pattern or name characters alike, unless o_stall
// holds a finished result; the rate is set by the cell row: match, shift and star closure
// ripple combinationally through all positions, like a carry chain
// reset (i_rst_n, synchronous, active low) empties the pattern, clears the active
// positions and flags; the pattern characters themselves are not cleared
module star_glob_matcher #(
    parameter int MAX_PATTERN = sgm_pkg::MAX_PATTERN_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // input channel
    input  logic       i_valid,
    output logic       o_stall,
    input  logic       i_operation,
    input  logic [7:0] i_character,
    input  logic       i_last,
    // result channel
    output logic       o_valid,
    input  logic       i_stall,
    output logic       o_matched,
    output logic       o_pattern_overflow
);
    import sgm_pkg::*;

    localparam int LW = $clog2(MAX_PATTERN + 1);

    // pattern bookkeeping
    logic [LW-1:0]          r_len;
    logic [LW-1:0]          n_len;
    logic                   r_ovf;
    logic                   n_ovf;
    logic                   r_restart;
    logic                   r_inprog;
    // active set of a fresh name (leading stars closed over position 0)
    logic [MAX_PATTERN-1:0] r_start;
    logic [MAX_PATTERN-1:0] n_start;
    logic [MAX_PATTERN-1:0] start_base;

    // output register
    logic                   r_ovalid;
    logic                   r_matched;
    logic                   r_povf;

    logic                   acc_in;
    logic                   load_acc;
    logic                   name_acc;
    logic [LW-1:0]          wr_idx;
    logic                   wr_ok;
    logic                   char_star;
    logic                   sel;

    t_link                  w_link [MAX_PATTERN:0];
    logic [MAX_PATTERN:0]   closed;

    // the input side only waits when a finished result is still held
    assign o_stall  = r_ovalid && i_stall;
    assign acc_in   = i_valid && !o_stall;
    assign load_acc = acc_in && (i_operation == OP_LOAD);
    assign name_acc = acc_in && (i_operation == OP_NAME);

    // a restart begins a new pattern at position zero
    assign wr_idx    = r_restart ? '0 : r_len;
    assign wr_ok     = wr_idx < LW'(MAX_PATTERN);
    assign char_star = (i_character == STAR_CHAR);

    always_comb begin
        n_len = wr_ok ? LW'(wr_idx + 1'b1) : r_len;
        n_ovf = (r_restart ? 1'b0 : r_ovf) || !wr_ok;
        start_base = r_start;
        if (r_restart) begin
            start_base    = '0;
            start_base[0] = 1'b1;
        end
        n_start = start_base;
        // a star written at a reachable position makes the position after it part of the fresh set
        for (int i = 1; i < MAX_PATTERN; i++) begin
            if (wr_ok && (wr_idx == LW'(i - 1))) begin
                n_start[i] = start_base[i-1] && char_star;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len     <= '0;
            r_ovf     <= 1'b0;
            r_restart <= 1'b1;
            r_start   <= '0;
            r_inprog  <= 1'b0;
        end else if (load_acc) begin
            r_len     <= n_len;
            r_ovf     <= n_ovf;
            r_restart <= i_last;
            r_start   <= n_start;
            // a pattern character abandons any name in progress
            r_inprog  <= 1'b0;
        end else if (name_acc) begin
            r_inprog  <= !i_last;
        end
    end

    // row of pattern cells; position zero has nothing on its left
    assign w_link[0] = '0;

    for (genvar g = 0; g < MAX_PATTERN; g++) begin : g_cell
        sgm_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_write     (load_acc && wr_ok && (wr_idx == LW'(g))),
            .i_character (i_character),
            .i_valid_pos (LW'(g) < r_len),
            .i_fresh     (!r_inprog),
            .i_start     (r_start[g]),
            .i_clear     (load_acc || (name_acc && i_last)),
            .i_update    (name_acc && !i_last),
            .i_link      (w_link[g]),
            .o_link      (w_link[g+1]),
            .o_closed    (closed[g])
        );
    end

    // the position past the last cell only collects, it never advances
    assign closed[MAX_PATTERN] = w_link[MAX_PATTERN].shift || w_link[MAX_PATTERN].carry;

    // whole-pattern match sits at the position equal to the length
    always_comb begin
        sel = 1'b0;
        for (int i = 0; i <= MAX_PATTERN; i++) begin
            if (r_len == LW'(i)) begin
                sel = closed[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (name_acc && i_last) begin
            r_ovalid <= 1'b1;
        end else if (!i_stall) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (name_acc && i_last) begin
            r_matched <= !r_ovf && sel;
            r_povf    <= r_ovf;
        end
    end

    assign o_valid            = r_ovalid;
    assign o_matched          = r_matched;
    assign o_pattern_overflow = r_povf;

`ifndef SYNTH
    a_ovf_no_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_pattern_overflow) |-> !o_matched)
        else $error("match reported against an overflowed pattern");

    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len <= LW'(MAX_PATTERN))
        else $error("pattern length beyond the store");

    a_ovf_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovf |-> (r_len == LW'(MAX_PATTERN)))
        else $error("overflow flagged with room left in the store");

    a_name_end_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (name_acc && i_last) |=> (o_valid && !r_inprog))
        else $error("name end without a result transaction");
`endif

endmodule

/* src/sgm_cell.sv */
module sgm_cell (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_write,
    input  logic [7:0]        i_character,
    input  logic              i_valid_pos,
    input  logic              i_fresh,
    input  logic              i_start,
    input  logic              i_clear,
    input  logic              i_update,
    input  sgm_pkg::t_link    i_link,
    output sgm_pkg::t_link    o_link,
    output logic              o_closed
);
    import sgm_pkg::*;

    logic [7:0] r_char;
    logic       r_active;
    logic       base;
    logic       is_star;
    logic       lit_hit;
    logic       closed;

    // pattern character held by this position
    always_ff @(posedge i_clk) begin
        if (i_write) begin
            r_char <= i_character;
        end
    end

    always_comb begin
        base     = i_fresh ? i_start : r_active;
        is_star  = i_valid_pos && (r_char == STAR_CHAR);
        lit_hit  = i_valid_pos && !is_star && (r_char == i_character);
        // a star keeps its own position and forwards the closure
        closed   = (base && is_star) || i_link.shift || i_link.carry;
        o_link.shift = base && lit_hit;
        o_link.carry = closed && is_star;
        o_closed     = closed;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
        end else if (i_clear) begin
            r_active <= 1'b0;
        end else if (i_update) begin
            r_active <= closed;
        end
    end

endmodule

/* sim/testbench.sv */
`timescale 1ns / 1ps

module testbench;

    localparam int DEPTH = sgm_pkg::MAX_PATTERN_DEF;
    localparam logic [7:0] STAR = sgm_pkg::STAR_CHAR;

    // sample bytes for the directed part
    localparam logic [7:0] CH_A = 8'h61;
    localparam logic [7:0] CH_B = 8'h62;
    localparam logic [7:0] CH_C = 8'h63;
    localparam logic [7:0] CH_X = 8'h78;
    localparam logic [7:0] CH_LOW = 8'h01;
    localparam logic [7:0] CH_MID = 8'h80;
    localparam logic [7:0] CH_HIGH = 8'hFF;

    localparam int RANDOM_CHARS = 2000;

    // one result transaction
    typedef struct packed {
        logic matched;
        logic overflow;
    } t_verdict;

    // tracks pattern and name state, keeps the verdicts still to come
    class glob_match_board;
        logic [7:0]   pat [DEPTH];
        int           pat_len;
        logic [DEPTH:0] live;
        bit           in_name;
        bit           overflowed;
        bit           restart;
        t_verdict     due[$];
        int           errors;

        function new();
            pat_len = 0;
            live = '0;
            in_name = 1'b0;
            overflowed = 1'b0;
            restart = 1'b1;
            errors = 0;
        endfunction

        // an active star also makes the position after it active
        function logic [DEPTH:0] spread_stars(logic [DEPTH:0] s);
            for (int i = 0; i < pat_len; i++)
                if (s[i] && pat[i] == STAR)
                    s[i + 1] = 1'b1;
            return s;
        endfunction

        function logic [DEPTH:0] consume(logic [DEPTH:0] s, logic [7:0] c);
            logic [DEPTH:0] nxt;
            nxt = '0;
            for (int i = 0; i < pat_len; i++) begin
                if (s[i]) begin
                    if (pat[i] == STAR)
                        nxt[i] = 1'b1;
                    else if (pat[i] == c)
                        nxt[i + 1] = 1'b1;
                end
            end
            return spread_stars(nxt);
        endfunction

        function void take_char(sgm_pkg::t_op op, logic [7:0] c, logic lst);
            t_verdict v;
            if (op == sgm_pkg::OP_LOAD) begin
                in_name = 1'b0;
                live = '0;
                if (restart) begin
                    pat_len = 0;
                    overflowed = 1'b0;
                    restart = 1'b0;
                end
                if (pat_len < DEPTH) begin
                    pat[pat_len] = c;
                    pat_len++;
                end else begin
                    overflowed = 1'b1;
                end
                if (lst)
                    restart = 1'b1;
            end else begin
                if (!in_name)
                    live = spread_stars((DEPTH + 1)'(1));
                live = consume(live, c);
                if (!lst) begin
                    in_name = 1'b1;
                end else begin
                    in_name = 1'b0;
                    v.matched = overflowed ? 1'b0 : live[pat_len];
                    v.overflow = overflowed;
                    due.push_back(v);
                    live = '0;
                end
            end
        endfunction

        function void check_verdict(logic m, logic ov);
            t_verdict want;
            if (due.size() == 0) begin
                $display("%0t: unexpected result matched=%0b overflow=%0b", $time, m, ov);
                errors++;
                return;
            end
            want = due.pop_front();
            if (m !== want.matched) begin
                $display("%0t: matched expected %0b got %0b", $time, want.matched, m);
                errors++;
            end
            if (ov !== want.overflow) begin
                $display("%0t: pattern_overflow expected %0b got %0b",
                         $time, want.overflow, ov);
                errors++;
            end
        endfunction

        function int pending();
            return due.size();
        endfunction
    endclass

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       i_valid;
    logic       o_stall;
    logic       i_operation;
    logic [7:0] i_character;
    logic       i_last;
    logic       o_valid;
    logic       i_stall;
    logic       o_matched;
    logic       o_pattern_overflow;

    glob_match_board board;
    bit              calm;        // no idling on either side while set
    int              chars_sent;

    star_glob_matcher DUT (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_valid),
        .o_stall            (o_stall),
        .i_operation        (i_operation),
        .i_character        (i_character),
        .i_last             (i_last),
        .o_valid            (o_valid),
        .i_stall            (i_stall),
        .o_matched          (o_matched),
        .o_pattern_overflow (o_pattern_overflow)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // mostly a small alphabet so that names hit the pattern, now and then any byte
    function automatic logic [7:0] pick_byte();
        if ($urandom_range(0, 9) < 9)
            return 8'(CH_A + $urandom_range(0, 2));
        return 8'($urandom_range(1, 255));
    endfunction

    // one input transaction, called at a falling edge, returns at a falling edge
    task automatic send_item(input sgm_pkg::t_op op, input logic [7:0] ch, input logic lst);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 19);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_operation <= op;
        i_character <= ch;
        i_last <= lst;
        do @(posedge i_clk); while (o_stall);
        board.take_char(op, ch, lst);
        chars_sent++;
        @(negedge i_clk);
    endtask

    // pattern chars, sometimes with a short name cut in before the pattern ends
    task automatic load_pattern(input logic [7:0] chars[$]);
        int extra;
        for (int i = 0; i < chars.size(); i++) begin
            send_item(sgm_pkg::OP_LOAD, chars[i], i == chars.size() - 1);
            if (i != chars.size() - 1 && $urandom_range(0, 99) < 3) begin
                extra = $urandom_range(1, 3);
                for (int j = 0; j < extra; j++)
                    send_item(sgm_pkg::OP_NAME, pick_byte(), j == extra - 1);
            end
        end
    endtask

    // a cut name never sees its last flag and is dropped by the next pattern char
    task automatic send_name(input logic [7:0] chars[$], input bit cut);
        for (int i = 0; i < chars.size(); i++)
            send_item(sgm_pkg::OP_NAME, chars[i], (i == chars.size() - 1) && !cut);
    endtask

    // stop sending until every expected verdict is back
    task automatic drain();
        i_valid <= 1'b0;
        while (board.pending() != 0)
            @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // result side: random stall ahead of each result transaction
    initial begin
        int hold;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever begin
            hold = calm ? 0 : $urandom_range(0, 19);
            if (hold > 0) begin
                i_stall <= 1'b1;
                repeat (hold) @(negedge i_clk);
                i_stall <= 1'b0;
            end
            do @(posedge i_clk); while (!o_valid);
            board.check_verdict(o_matched, o_pattern_overflow);
            @(negedge i_clk);
        end
    end

    // stimulus
    initial begin
        logic [7:0] pt[$];
        logic [7:0] nm[$];
        int         goal;
        int         round;
        int         plen;
        int         k;
        int         nnames;
        int         m;
        bit         cut;

        board = new();
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_operation = 1'b0;
        i_character = 8'h00;
        i_last = 1'b0;
        i_stall = 1'b0;
        calm = 1'b0;
        chars_sent = 0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // nothing loaded yet, the empty pattern rejects any name
        send_item(sgm_pkg::OP_NAME, CH_A, 1'b1);
        // pattern of two stars, trailing stars match the empty remainder
        send_item(sgm_pkg::OP_LOAD, STAR, 1'b0);
        send_item(sgm_pkg::OP_LOAD, STAR, 1'b1);
        send_item(sgm_pkg::OP_NAME, CH_HIGH, 1'b1);
        // name against a pattern still being loaded
        send_item(sgm_pkg::OP_LOAD, CH_A, 1'b0);
        send_item(sgm_pkg::OP_NAME, CH_A, 1'b1);
        // more pattern chars append to the same pattern, giving "ab"
        send_item(sgm_pkg::OP_LOAD, CH_B, 1'b1);
        send_item(sgm_pkg::OP_NAME, CH_A, 1'b0);
        send_item(sgm_pkg::OP_NAME, CH_B, 1'b1);
        // name abandoned by a pattern char, new pattern "c*"
        send_item(sgm_pkg::OP_NAME, CH_X, 1'b0);
        send_item(sgm_pkg::OP_LOAD, CH_C, 1'b0);
        send_item(sgm_pkg::OP_LOAD, STAR, 1'b1);
        send_item(sgm_pkg::OP_NAME, CH_C, 1'b1);
        send_item(sgm_pkg::OP_NAME, CH_LOW, 1'b0);
        send_item(sgm_pkg::OP_NAME, CH_C, 1'b1);
        // extreme bytes around a star
        send_item(sgm_pkg::OP_LOAD, CH_LOW, 1'b0);
        send_item(sgm_pkg::OP_LOAD, STAR, 1'b0);
        send_item(sgm_pkg::OP_LOAD, CH_HIGH, 1'b1);
        send_item(sgm_pkg::OP_NAME, CH_LOW, 1'b0);
        send_item(sgm_pkg::OP_NAME, CH_MID, 1'b0);
        send_item(sgm_pkg::OP_NAME, CH_HIGH, 1'b1);
        send_item(sgm_pkg::OP_NAME, CH_LOW, 1'b1);

        // random rounds: a fresh pattern, then names built mostly from it
        goal = chars_sent + RANDOM_CHARS;
        round = 0;
        while (chars_sent < goal) begin
            calm = ($urandom_range(0, 4) == 0);
            k = $urandom_range(0, 99);
            // first rounds: a full store, then one char too many
            if (round == 0)
                plen = DEPTH;
            else if (round == 1)
                plen = DEPTH + 1;
            else if (k < 80)
                plen = $urandom_range(1, 8);
            else if (k < 95)
                plen = $urandom_range(9, DEPTH);
            else
                plen = $urandom_range(DEPTH + 1, DEPTH + 8);
            pt.delete();
            for (int j = 0; j < plen; j++)
                pt.push_back(($urandom_range(0, 9) < 3) ? STAR : pick_byte());
            load_pattern(pt);
            if (round == 20 || round == 200)
                drain();

            nnames = $urandom_range(1, 6);
            for (int n = 0; n < nnames; n++) begin
                nm.delete();
                m = $urandom_range(0, 9);
                if (m < 8) begin
                    // expand the stars, keep the literals
                    foreach (pt[j]) begin
                        if (pt[j] == STAR) begin
                            repeat ($urandom_range(0, 3)) nm.push_back(pick_byte());
                        end else begin
                            nm.push_back(pt[j]);
                        end
                    end
                    if (nm.size() == 0)
                        nm.push_back(pick_byte());
                    // near miss: one char replaced
                    if (m >= 6)
                        nm[$urandom_range(0, nm.size() - 1)] = pick_byte();
                end else begin
                    repeat ($urandom_range(1, 8)) nm.push_back(pick_byte());
                end
                cut = (n == nnames - 1) && ($urandom_range(0, 19) == 0);
                send_name(nm, cut);
            end
            round++;
        end

        drain();
        repeat (8) @(posedge i_clk);
        if (board.pending() != 0) begin
            $display("%0t: %0d expected results never arrived", $time, board.pending());
            board.errors++;
        end
        if (board.errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    // watchdog
    initial begin
        #3_000_000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule
